// ----- src/id3p_pkg.sv -----
// id3p_pkg: shared types and constants of the id3v2 tag parser
// command record passed from the parse front to the result back end
// no dependencies
package id3p_pkg;

    localparam int MAX_IMAGE   = 16384;
    localparam int PEEK_WINDOW = 256;
    localparam int HDR_LEN     = 10;
    localparam int PIC_CNT_W   = 15;
    localparam int PIC_IDX_W   = 14;
    localparam int START_W     = 29;
    localparam int TAG_LEN_W   = 28;
    localparam int REP_W       = 4;
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = 2;

    typedef enum logic [2:0] {
        CMD_AUDIO     = 3'd0,
        CMD_PIC       = 3'd1,
        CMD_SUM       = 3'd2,
        CMD_SUM_AUDIO = 3'd3,
        CMD_PIC_SUM   = 3'd4,
        CMD_NOTAG     = 3'd5
    } cmd_op_t;

    typedef enum logic [1:0] {
        KIND_AUDIO   = 2'd0,
        KIND_PICTURE = 2'd1,
        KIND_SUMMARY = 2'd2
    } result_kind_t;

    typedef struct packed {
        cmd_op_t                     op;
        logic [7:0]                  data;
        logic [PIC_IDX_W-1:0]        idx;
        logic [START_W-1:0]          start;
        logic                        found;
        logic [PIC_CNT_W-1:0]        len;
        logic [REP_W-1:0]            rep_cnt;
        logic [HDR_LEN-1:0][7:0]     hdr;
    } cmd_t;

endpackage

// ----- src/id3v2_tag_parser_unit.sv -----
// id3v2_tag_parser_unit: top level of the id3v2 tag parser with picture capture
// parse front, command queue and result back end; depends on id3p_pkg
//
// usage
// - slave stream: one file byte per transaction in s_tdata, s_tlast on the final byte
// - master stream: results, kind in m_tuser, fields in m_tdata, m_tlast on the final
//   result caused by one input byte
// - a byte is classified in the cycle it is accepted; its results reach m_tvalid
//   through the command queue and then the output register
// - throughput is one byte per cycle while results flow one per cycle; the back end
//   emits one result per cycle while m_tready is high, so while the up to eleven
//   results of a file without a tag drain, the four-entry command queue fills
// - a stalled receiver holds the output register; the front keeps accepting until
//   the queue is full, then s_tready drops
// - reset empties the queue and returns the parser to the header phase
module id3v2_tag_parser_unit
    import id3p_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // byte_value, picture_index, audio_start, art_found,
                                   // picture_length, zero fill
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // last_of_run
);

    logic f_valid, f_ready;
    cmd_t f_cmd;
    logic b_valid, b_ready;
    cmd_t b_cmd;

    id3p_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd_ready (f_ready),
        .cmd_valid (f_valid),
        .cmd       (f_cmd)
    );

    id3p_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_cmd   (b_cmd)
    );

    id3p_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd       (b_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- src/id3p_front.sv -----
// id3p_front: accepts file bytes, walks the id3v2 header and frames
// issues one command per byte that causes results; depends on id3p_pkg
module id3p_front
    import id3p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // data_byte
    input  logic       s_tlast,     // end_of_file
    input  logic       cmd_ready,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    typedef enum logic [7:0] {
        PH_HDR   = 8'b0000_0001,
        PH_FHDR  = 8'b0000_0010,
        PH_SKIP  = 8'b0000_0100,
        PH_MIME  = 8'b0000_1000,
        PH_DESC  = 8'b0001_0000,
        PH_DATA  = 8'b0010_0000,
        PH_PAD   = 8'b0100_0000,
        PH_AUDIO = 8'b1000_0000
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [31:0]             pos_reg, pos_next;
    logic [TAG_LEN_W-1:0]    tag_len_reg, tag_len_next;
    logic [31:0]             frem_reg, frem_next;
    logic [31:0]             off_reg, off_next;
    logic [31:0]             pend_reg, pend_next;
    logic [PIC_CNT_W-1:0]    pcnt_reg, pcnt_next;
    logic                    seen_reg, seen_next;
    logic [HDR_LEN-1:0][7:0] hdr_reg;
    logic [7:0][7:0]         fhdr_reg;
    logic [31:0]             fsize_reg, fsize_next;
    logic                    fhdr_wr;

    logic [HDR_LEN-1:0][7:0] hdr_cur;
    logic [REP_W-1:0]        have;
    logic                    accept;
    logic                    notag, pre_sum, emit_audio, emit_pic, post_sum;
    logic [START_W-1:0]      tag_end_cur, tag_end_next;
    logic [31:0]             fs_new;
    logic [31:0]             frem_dec;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = cmd_ready;

    assign tag_end_cur  = START_W'(HDR_LEN) + {1'b0, tag_len_reg};
    assign tag_end_next = START_W'(HDR_LEN) + {1'b0, tag_len_next};
    assign fs_new       = {fhdr_reg[4], fhdr_reg[5], fhdr_reg[6], fhdr_reg[7]};
    assign have         = pos_reg[REP_W-1:0] + REP_W'(1);
    assign frem_dec     = (frem_reg != 32'd0) ? frem_reg - 32'd1 : frem_reg;

    always_comb
    begin
        hdr_cur = hdr_reg;
        if (pos_reg < 32'(HDR_LEN))
        begin
            hdr_cur[pos_reg[REP_W-1:0]] = s_tdata;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        tag_len_next = tag_len_reg;
        frem_next    = frem_reg;
        off_next     = off_reg;
        pend_next    = pend_reg;
        pcnt_next    = pcnt_reg;
        seen_next    = seen_reg;
        fsize_next   = fsize_reg;
        fhdr_wr      = 1'b0;
        notag        = 1'b0;
        pre_sum      = 1'b0;
        emit_audio   = 1'b0;
        emit_pic     = 1'b0;
        post_sum     = 1'b0;
        pos_next     = pos_reg;
        if (accept)
        begin
            if (pos_reg != 32'hFFFF_FFFF)
            begin
                pos_next = pos_reg + 32'd1;
            end
            if (phase_reg == PH_HDR)
            begin
                if (have == REP_W'(HDR_LEN) || s_tlast)
                begin
                    if (have == REP_W'(HDR_LEN) && hdr_cur[0] == 8'h49 &&
                        hdr_cur[1] == 8'h44 && hdr_cur[2] == 8'h33)
                    begin
                        tag_len_next = {hdr_cur[6][6:0], hdr_cur[7][6:0],
                                        hdr_cur[8][6:0], hdr_cur[9][6:0]};
                        phase_next   = PH_FHDR;
                        off_next     = 32'd0;
                    end
                    else
                    begin
                        notag      = 1'b1;
                        phase_next = PH_AUDIO;
                    end
                end
            end
            else if (phase_reg == PH_AUDIO)
            begin
                emit_audio = 1'b1;
            end
            else if (pos_reg >= {3'b000, tag_end_cur})
            begin
                pre_sum    = 1'b1;
                phase_next = PH_AUDIO;
            end
            else if (phase_reg == PH_FHDR)
            begin
                if (off_reg == 32'd0 &&
                    ({1'b0, pos_reg} + 33'd10) > {4'b0000, tag_end_cur})
                begin
                    phase_next = PH_PAD;
                end
                else if (off_reg == 32'd9)
                begin
                    off_next   = 32'd0;
                    frem_next  = fs_new;
                    fsize_next = fs_new;
                    if (fs_new == 32'd0)
                    begin
                        phase_next = PH_PAD;
                    end
                    else if (!seen_reg && fhdr_reg[0] == 8'h41 && fhdr_reg[1] == 8'h50 &&
                             fhdr_reg[2] == 8'h49 && fhdr_reg[3] == 8'h43)
                    begin
                        phase_next = PH_MIME;
                        pend_next  = 32'd1;
                        pcnt_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                else
                begin
                    fhdr_wr  = (off_reg < 32'd8);
                    off_next = off_reg + 32'd1;
                end
            end
            else if (phase_reg != PH_PAD)
            begin
                if ((phase_reg == PH_MIME || phase_reg == PH_DESC) && off_reg == pend_reg)
                begin
                    if (off_reg < fsize_reg && off_reg < 32'(PEEK_WINDOW) &&
                        s_tdata != 8'd0)
                    begin
                        pend_next = off_reg + 32'd1;
                    end
                    else if (phase_reg == PH_MIME)
                    begin
                        pend_next  = off_reg + 32'd2;
                        phase_next = PH_DESC;
                    end
                    else
                    begin
                        pend_next  = off_reg + 32'd1;
                        phase_next = PH_DATA;
                    end
                end
                else if (phase_reg == PH_DATA && off_reg >= pend_reg &&
                         pcnt_reg < PIC_CNT_W'(MAX_IMAGE))
                begin
                    emit_pic  = 1'b1;
                    pcnt_next = pcnt_reg + PIC_CNT_W'(1);
                    seen_next = 1'b1;
                end
                frem_next = frem_dec;
                if (frem_dec == 32'd0)
                begin
                    phase_next = PH_FHDR;
                    off_next   = 32'd0;
                end
                else
                begin
                    off_next = off_reg + 32'd1;
                end
            end
            if (s_tlast && phase_next != PH_AUDIO)
            begin
                post_sum   = 1'b1;
                phase_next = PH_AUDIO;
            end
        end
    end

    always_comb
    begin
        cmd_valid   = notag || pre_sum || emit_audio || emit_pic || post_sum;
        cmd.data    = s_tdata;
        cmd.idx     = pcnt_reg[PIC_IDX_W-1:0];
        cmd.start   = notag ? '0 : tag_end_next;
        cmd.found   = notag ? 1'b0 : seen_next;
        cmd.len     = notag ? '0 : pcnt_next;
        cmd.rep_cnt = have;
        cmd.hdr     = hdr_cur;
        if (notag)
        begin
            cmd.op = CMD_NOTAG;
        end
        else if (pre_sum)
        begin
            cmd.op = CMD_SUM_AUDIO;
        end
        else if (emit_audio)
        begin
            cmd.op = CMD_AUDIO;
        end
        else if (emit_pic)
        begin
            cmd.op = post_sum ? CMD_PIC_SUM : CMD_PIC;
        end
        else
        begin
            cmd.op = CMD_SUM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR;
            pos_reg     <= '0;
            tag_len_reg <= '0;
            frem_reg    <= '0;
            off_reg     <= '0;
            pend_reg    <= '0;
            pcnt_reg    <= '0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            tag_len_reg <= tag_len_next;
            frem_reg    <= frem_next;
            off_reg     <= off_next;
            pend_reg    <= pend_next;
            pcnt_reg    <= pcnt_next;
            seen_reg    <= seen_next;
        end
    end

    // header and frame header bytes, and the frame size
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_HDR)
        begin
            hdr_reg <= hdr_cur;
        end
        if (fhdr_wr)
        begin
            fhdr_reg[off_reg[2:0]] <= s_tdata;
        end
        fsize_reg <= fsize_next;
    end

endmodule

// ----- src/id3p_fifo.sv -----
// id3p_fifo: short command queue between parse front and result back end
// depends on id3p_pkg
module id3p_fifo
    import id3p_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t                  mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMDQ_PTR_W:0]   cnt_reg, cnt_next;
    logic                  push, pop;

    assign in_ready  = (cnt_reg != (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (CMDQ_PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (CMDQ_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- src/id3p_back.sv -----
// id3p_back: expands queued commands into result transactions
// drives the registered master stream; depends on id3p_pkg
module id3p_back
    import id3p_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // byte_value, picture_index, audio_start, art_found,
                                   // picture_length, zero fill
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // last_of_run
);

    logic                 mv_reg, mv_next;
    logic [REP_W-1:0]     seq_reg, seq_next;
    logic [1:0]           kind_reg, r_kind;
    logic [7:0]           byte_reg, r_byte;
    logic [PIC_IDX_W-1:0] idx_reg, r_idx;
    logic [START_W-1:0]   start_reg, r_start;
    logic                 found_reg, r_found;
    logic [PIC_CNT_W-1:0] len_reg, r_len;
    logic                 last_reg, r_last;
    logic                 load;
    logic [REP_W-1:0]     rep_sel;

    assign load      = cmd_valid && (!mv_reg || m_tready);
    assign cmd_ready = load && r_last;
    assign rep_sel   = seq_reg - REP_W'(1);

    always_comb
    begin
        r_kind  = KIND_AUDIO;
        r_byte  = 8'd0;
        r_idx   = '0;
        r_start = '0;
        r_found = 1'b0;
        r_len   = '0;
        r_last  = 1'b1;
        case (cmd.op)
            CMD_AUDIO:
            begin
                r_byte = cmd.data;
            end
            CMD_PIC:
            begin
                r_kind = KIND_PICTURE;
                r_byte = cmd.data;
                r_idx  = cmd.idx;
            end
            CMD_SUM:
            begin
                r_kind  = KIND_SUMMARY;
                r_start = cmd.start;
                r_found = cmd.found;
                r_len   = cmd.len;
            end
            CMD_SUM_AUDIO:
            begin
                if (seq_reg == '0)
                begin
                    r_kind  = KIND_SUMMARY;
                    r_start = cmd.start;
                    r_found = cmd.found;
                    r_len   = cmd.len;
                    r_last  = 1'b0;
                end
                else
                begin
                    r_byte = cmd.data;
                end
            end
            CMD_PIC_SUM:
            begin
                if (seq_reg == '0)
                begin
                    r_kind = KIND_PICTURE;
                    r_byte = cmd.data;
                    r_idx  = cmd.idx;
                    r_last = 1'b0;
                end
                else
                begin
                    r_kind  = KIND_SUMMARY;
                    r_start = cmd.start;
                    r_found = cmd.found;
                    r_len   = cmd.len;
                end
            end
            CMD_NOTAG:
            begin
                if (seq_reg == '0)
                begin
                    r_kind = KIND_SUMMARY;
                    r_last = 1'b0;
                end
                else
                begin
                    r_byte = cmd.hdr[rep_sel];
                    r_last = (seq_reg == cmd.rep_cnt);
                end
            end
            default:
            begin
                r_byte = cmd.data;
            end
        endcase
    end

    always_comb
    begin
        mv_next  = mv_reg;
        seq_next = seq_reg;
        if (load)
        begin
            mv_next  = 1'b1;
            seq_next = r_last ? '0 : seq_reg + REP_W'(1);
        end
        else if (m_tready)
        begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg  <= 1'b0;
            seq_reg <= '0;
        end
        else
        begin
            mv_reg  <= mv_next;
            seq_reg <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= r_kind;
            byte_reg  <= r_byte;
            idx_reg   <= r_idx;
            start_reg <= r_start;
            found_reg <= r_found;
            len_reg   <= r_len;
            last_reg  <= r_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'd0, len_reg, found_reg, start_reg, idx_reg, byte_reg};

endmodule
